FILE: design/generative_four_voice_sequencer_assert.svh
// Assertion macros for the four-voice sequencer.
// Needs a clock aclk and an active-low reset aresetn in the including scope.
`ifndef GENERATIVE_FOUR_VOICE_SEQUENCER_ASSERT_SVH
`define GENERATIVE_FOUR_VOICE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define GFVS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GFVS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gfvs_pkg.sv
// Shared constants, preset tables and unit interface types of the sequencer.
// No dependencies.
package gfvs_pkg;

    localparam int VOICE_COUNT = 4;
    localparam int TRACK_COUNT = 4;
    localparam int SCALE_STEPS = 12;

    localparam logic [2:0] CFG_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_ALGO_X  = 3'd1;
    localparam logic [2:0] CFG_ALGO_Y  = 3'd2;
    localparam logic [2:0] CFG_SHIFT   = 3'd3;
    localparam logic [2:0] CFG_SPACE   = 3'd4;
    localparam logic [2:0] CFG_SCALE_A = 3'd5;
    localparam logic [2:0] CFG_SCALE_B = 3'd6;

    localparam logic [3:0] GATE_ROWS [16][4] = '{
        '{4'h1, 4'h2, 4'h4, 4'h8}, '{4'h3, 4'h2, 4'h5, 4'h8},
        '{4'h3, 4'h6, 4'hD, 4'h8}, '{4'h7, 4'h6, 4'hD, 4'h9},
        '{4'h7, 4'h5, 4'hD, 4'hA}, '{4'hF, 4'h5, 4'hE, 4'hA},
        '{4'hD, 4'hD, 4'hA, 4'hB}, '{4'hD, 4'h8, 4'h6, 4'hD},
        '{4'h9, 4'hC, 4'hE, 4'h7}, '{4'hC, 4'h5, 4'h6, 4'h7},
        '{4'hC, 4'h6, 4'h6, 4'hC}, '{4'h5, 4'hA, 4'h6, 4'hD},
        '{4'h5, 4'h9, 4'h6, 4'h5}, '{4'h6, 4'h5, 4'h6, 4'hD},
        '{4'hC, 4'h3, 4'h6, 4'hC}, '{4'h9, 4'h2, 4'h5, 4'h8}
    };

    localparam logic [3:0] SPACE_ROWS [16] = '{
        4'h0, 4'h1, 4'h2, 4'h4, 4'h8, 4'h3, 4'h5, 4'h9,
        4'h6, 4'hA, 4'hC, 4'h7, 4'hB, 4'hD, 4'hE, 4'hF
    };

    localparam logic [2:0] TRACK_WEIGHT [4] = '{3'd1, 3'd2, 3'd4, 3'd7};

    typedef struct packed {
        logic       start;
        logic [5:0] dividend;
        logic [3:0] divisor;
    } dm_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [5:0] quot;
        logic [3:0] rem;
    } dm_rsp_t;

endpackage

FILE: design/gfvs_divmod.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on gfvs_pkg for the request and response types.
module gfvs_divmod (
    input  logic              aclk,
    input  logic              aresetn,
    input  gfvs_pkg::dm_req_t req,
    output gfvs_pkg::dm_rsp_t rsp
);

    logic       busy_reg;
    logic       done_reg;
    logic [2:0] cnt_reg;
    logic [5:0] quot_reg;
    logic [3:0] rem_reg;
    logic [3:0] dvsr_reg;
    logic [4:0] trial;
    logic       fits;

    assign trial = {rem_reg, quot_reg[5]};
    assign fits  = trial >= {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd6;
                quot_reg <= req.dividend;
                rem_reg  <= '0;
                dvsr_reg <= req.divisor;
            end else if (busy_reg) begin
                rem_reg  <= fits ? 4'(trial - {1'b0, dvsr_reg}) : trial[3:0];
                quot_reg <= {quot_reg[4:0], fits};
                cnt_reg  <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: design/generative_four_voice_sequencer.sv
// Each accepted tick runs through divider passes and scale scans, and output stalls lengthen
// its work; with an empty scale the per-voice divider passes and scale scans are skipped.
// A new tick is taken only once the last is through: s_tready is low while a tick is in work.
// Four results follow per tick, one per voice, each held in the output register until taken.
// Reset (aresetn, synchronous): counters and voice state cleared, change flags set, scale A,
// length 8 and other config registers zero. Uses gfvs_pkg, gfvs_divmod and the assertion header.
`include "generative_four_voice_sequencer_assert.svh"

module generative_four_voice_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // reset_flag, toggle_scale, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // voice_index[1:0], semitone[5:2], octave[7:6],
                                   // gate_trigger, space_muted, mod_gate, mod_level[13:11],
                                   // cycle_restart, zero fill
    output logic        m_tlast    // last_voice
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_PH_START = 11'b00000000010,
        ST_PH_WAIT  = 11'b00000000100,
        ST_ON_START = 11'b00000001000,
        ST_ON_WAIT  = 11'b00000010000,
        ST_GATE     = 11'b00000100000,
        ST_POP      = 11'b00001000000,
        ST_V_START  = 11'b00010000000,
        ST_V_WAIT   = 11'b00100000000,
        ST_SCAN     = 11'b01000000000,
        ST_EMIT     = 11'b10000000000
    } state_t;

    state_t      state_reg;
    logic [5:0]  len_reg;
    logic [6:0]  algo_x_reg;
    logic [6:0]  algo_y_reg;
    logic [3:0]  shift_reg;
    logic [3:0]  space_pat_reg;
    logic [11:0] scale_a_reg;
    logic [11:0] scale_b_reg;

    logic [4:0]  step_reg;
    logic [3:0]  space_reg;
    logic        sel_scale_reg;
    logic        restart_reg;
    logic [3:0]  gate_on_reg;
    logic [3:0]  gate_chg_reg;
    logic [5:0]  note_reg [4];
    logic [2:0]  div_reg [4];
    logic [2:0]  ph_reg [4];
    logic [3:0]  on_reg;
    logic [1:0]  idx_reg;
    logic [3:0]  bit_reg;
    logic [3:0]  count_reg;
    logic [3:0]  seen_reg;
    logic        found_reg;
    logic [3:0]  semi_reg;
    logic [3:0]  k_reg;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg;

    gfvs_pkg::dm_req_t dm_req;
    gfvs_pkg::dm_rsp_t dm_rsp;

    gfvs_divmod u_divmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dm_req),
        .rsp     (dm_rsp)
    );

    logic        s_hs;
    logic [2:0]  div_new [4];
    logic [5:0]  len_eff;
    logic [3:0]  shift_eff;
    logic [11:0] smask;
    logic [2:0]  won [4];
    logic [3:0]  gmask;
    logic [3:0]  gword;
    logic        gchg;
    logic [5:0]  note_new;
    logic [4:0]  mod_raw [4];
    logic [4:0]  mod_dec;
    logic [2:0]  mod_lvl;
    logic [1:0]  octave;
    logic        space_mute;
    logic [4:0]  ph_num;
    logic [1:0]  idx_p1;
    logic [1:0]  idx_p2;
    logic [1:0]  idx_p3;

    assign s_hs      = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign len_eff   = (len_reg == 6'd0) ? 6'd1 : ((len_reg > 6'd32) ? 6'd32 : len_reg);
    assign shift_eff = (shift_reg > 4'd12) ? 4'd12 : shift_reg;
    assign smask     = sel_scale_reg ? scale_b_reg : scale_a_reg;
    assign idx_p1    = idx_reg + 2'd1;
    assign idx_p2    = idx_reg + 2'd2;
    assign idx_p3    = idx_reg + 2'd3;

    always_comb begin
        div_new[0] = {1'b0, algo_x_reg[1:0]} + 3'd1;
        for (int i = 1; i < gfvs_pkg::TRACK_COUNT; i++) begin
            div_new[i] = algo_x_reg[i + 2] ? div_new[i - 1] + 3'd1 : div_new[i - 1] - 3'd1;
            if (div_new[i] == 3'd0) begin
                div_new[i] = 3'(i + 2);
            end
        end
    end

    always_comb begin
        unique case (idx_reg)
            2'd0:    ph_num = 5'd0;
            2'd1:    ph_num = {2'b0, algo_x_reg[2:1], 1'b0} + 5'd1;
            2'd2:    ph_num = {1'b0, algo_x_reg[3:2], 2'b0} + 5'd2;
            default: ph_num = {algo_x_reg[4:3], 3'b0} + 5'd3;
        endcase
    end

    always_comb begin
        for (int i = 0; i < gfvs_pkg::TRACK_COUNT; i++) begin
            won[i] = on_reg[i] ? gfvs_pkg::TRACK_WEIGHT[i] : 3'd0;
        end
    end

    // gate and note of voice idx_reg
    always_comb begin
        logic [3:0] m;
        logic       prev;
        m = gfvs_pkg::GATE_ROWS[algo_y_reg[6:3]][idx_reg];
        if (m == 4'd0) begin
            m = 4'h5;
        end
        unique case (idx_reg)
            2'd0:    gmask = m;
            2'd1:    gmask = {m[0], m[3:1]};
            2'd2:    gmask = {m[1:0], m[3:2]};
            default: gmask = {m[2:0], m[3]};
        endcase
        gword = {3'b0, |(on_reg & gmask)};
        if (algo_y_reg[0]) begin
            gword = gword ^ {2'b0, on_reg[idx_reg], 1'b0};
        end
        if (algo_y_reg[1]) begin
            gword = gword ^ {1'b0, on_reg[idx_p2], 2'b0};
        end
        if (algo_y_reg[2]) begin
            gword = gword ^ {on_reg[idx_p3], 3'b0};
        end
        prev = &(gate_chg_reg[2:0] & gate_on_reg[2:0]);
        if (idx_reg == 2'd3 && prev) begin
            gword = 4'd0;
        end
        gchg = gword != {3'b0, gate_on_reg[idx_reg]};

        note_new = 6'd0;
        for (int i = 0; i < gfvs_pkg::TRACK_COUNT; i++) begin
            if (algo_y_reg[i + 3]) begin
                note_new = note_new + {3'b0, won[i]};
            end
        end
        if (algo_y_reg[0]) begin
            note_new = note_new + {3'b0, won[idx_p1]};
        end
        if (algo_y_reg[1]) begin
            note_new = note_new + {3'b0, won[idx_p2]};
        end
        if (algo_y_reg[2]) begin
            note_new = note_new + {3'b0, won[idx_p3]};
        end
        note_new = note_new + {2'b0, shift_eff};
        if (shift_eff > 4'd6) begin
            note_new = note_new + {4'b0, idx_reg};
        end
    end

    always_comb begin
        logic [1:0] o0, o1, o2, o3;
        o0 = {1'b0, on_reg[0]};
        o1 = {1'b0, on_reg[1]};
        o2 = {1'b0, on_reg[2]};
        o3 = {1'b0, on_reg[3]};
        mod_raw[0] = 5'(won[0]) + 5'(won[1]) + 5'(won[2]) + 5'(won[3]) + 5'(won[0]);
        mod_raw[1] = 5'(2'(o3 + o2)) * 5'd2 + 5'(2'(o0 + o2)) * 5'd4;
        mod_raw[2] = 5'(2'(o2 + o1)) + 5'(2'(o0 + o3)) * 5'd7;
        mod_raw[3] = 5'(2'(o1 + o2)) * 5'd2 + 5'(2'(o2 + o3)) * 5'd4
                   + 5'(2'(o3 + o2)) * 5'd7;
        if (mod_raw[idx_reg] >= 5'd20) begin
            mod_dec = mod_raw[idx_reg] - 5'd20;
        end else if (mod_raw[idx_reg] >= 5'd10) begin
            mod_dec = mod_raw[idx_reg] - 5'd10;
        end else begin
            mod_dec = mod_raw[idx_reg];
        end
        mod_lvl = mod_dec[2:0];
    end

    assign octave = (note_reg[idx_reg] >= 6'd24) ? 2'd2 :
                    ((note_reg[idx_reg] >= 6'd12) ? 2'd1 : 2'd0);
    assign space_mute = |(gfvs_pkg::SPACE_ROWS[space_pat_reg | {2'b0, idx_reg}] & space_reg);

    always_comb begin
        dm_req.start    = 1'b0;
        dm_req.dividend = 6'd0;
        dm_req.divisor  = {1'b0, div_reg[idx_reg]};
        unique case (state_reg)
            ST_PH_START: begin
                dm_req.start    = 1'b1;
                dm_req.dividend = {1'b0, ph_num};
            end
            ST_ON_START: begin
                dm_req.start    = 1'b1;
                dm_req.dividend = {1'b0, step_reg} + {3'b0, ph_reg[idx_reg]};
            end
            ST_V_START: begin
                dm_req.start    = (count_reg != 4'd0);
                dm_req.dividend = note_reg[idx_reg];
                dm_req.divisor  = count_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= 6'd8;
            algo_x_reg    <= '0;
            algo_y_reg    <= '0;
            shift_reg     <= '0;
            space_pat_reg <= '0;
            scale_a_reg   <= '0;
            scale_b_reg   <= '0;
            step_reg      <= '0;
            space_reg     <= '0;
            sel_scale_reg <= 1'b0;
            restart_reg   <= 1'b0;
            gate_on_reg   <= '0;
            gate_chg_reg  <= '1;
            for (int i = 0; i < gfvs_pkg::VOICE_COUNT; i++) begin
                note_reg[i] <= '0;
            end
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    gfvs_pkg::CFG_LENGTH:  len_reg       <= cfg_wdata[5:0];
                    gfvs_pkg::CFG_ALGO_X:  algo_x_reg    <= cfg_wdata[6:0];
                    gfvs_pkg::CFG_ALGO_Y:  algo_y_reg    <= cfg_wdata[6:0];
                    gfvs_pkg::CFG_SHIFT:   shift_reg     <= cfg_wdata[3:0];
                    gfvs_pkg::CFG_SPACE:   space_pat_reg <= cfg_wdata[3:0];
                    gfvs_pkg::CFG_SCALE_A: scale_a_reg   <= cfg_wdata;
                    gfvs_pkg::CFG_SCALE_B: scale_b_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_hs) begin
                        sel_scale_reg <= sel_scale_reg ^ s_tdata[1];
                        for (int i = 0; i < gfvs_pkg::TRACK_COUNT; i++) begin
                            div_reg[i] <= div_new[i];
                        end
                        ph_reg[0] <= {1'b0, algo_x_reg[6:5]};
                        if (s_tdata[0]) begin
                            step_reg    <= '0;
                            space_reg   <= '0;
                            restart_reg <= 1'b1;
                        end else begin
                            space_reg <= space_reg + 4'd1;
                            if ({1'b0, step_reg} + 6'd1 >= len_eff) begin
                                step_reg    <= '0;
                                restart_reg <= 1'b1;
                            end else begin
                                step_reg    <= step_reg + 5'd1;
                                restart_reg <= 1'b0;
                            end
                        end
                        idx_reg   <= 2'd1;
                        state_reg <= ST_PH_START;
                    end
                end
                ST_PH_START: state_reg <= ST_PH_WAIT;
                ST_PH_WAIT: begin
                    if (dm_rsp.done) begin
                        ph_reg[idx_reg] <= dm_rsp.rem[2:0];
                        idx_reg         <= idx_p1;
                        state_reg       <= (idx_reg == 2'd3) ? ST_ON_START : ST_PH_START;
                    end
                end
                ST_ON_START: state_reg <= ST_ON_WAIT;
                ST_ON_WAIT: begin
                    if (dm_rsp.done) begin
                        on_reg[idx_reg] <= dm_rsp.quot[0];
                        idx_reg         <= idx_p1;
                        state_reg       <= (idx_reg == 2'd3) ? ST_GATE : ST_ON_START;
                    end
                end
                ST_GATE: begin
                    gate_chg_reg[idx_reg] <= gchg;
                    gate_on_reg[idx_reg]  <= gword != 4'd0;
                    if (gchg) begin
                        note_reg[idx_reg] <= note_new;
                    end
                    idx_reg   <= idx_p1;
                    bit_reg   <= '0;
                    count_reg <= '0;
                    if (idx_reg == 2'd3) begin
                        state_reg <= ST_POP;
                    end
                end
                ST_POP: begin
                    count_reg <= count_reg + {3'b0, smask[bit_reg]};
                    bit_reg   <= bit_reg + 4'd1;
                    if (bit_reg == 4'(gfvs_pkg::SCALE_STEPS - 1)) begin
                        idx_reg   <= 2'd0;
                        state_reg <= ST_V_START;
                    end
                end
                ST_V_START: begin
                    semi_reg  <= '0;
                    state_reg <= (count_reg == 4'd0) ? ST_EMIT : ST_V_WAIT;
                end
                ST_V_WAIT: begin
                    if (dm_rsp.done) begin
                        k_reg     <= dm_rsp.rem;
                        bit_reg   <= '0;
                        seen_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (smask[bit_reg]) begin
                        if (seen_reg == k_reg && !found_reg) begin
                            semi_reg  <= bit_reg;
                            found_reg <= 1'b1;
                        end
                        seen_reg <= seen_reg + 4'd1;
                    end
                    bit_reg <= bit_reg + 4'd1;
                    if (bit_reg == 4'(gfvs_pkg::SCALE_STEPS - 1)) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tlast_reg  <= (idx_reg == 2'd3);
                        m_tdata_reg  <= {1'b0, restart_reg, mod_lvl, on_reg[idx_reg],
                                         space_mute,
                                         (count_reg != 4'd0) && gate_chg_reg[idx_reg],
                                         (count_reg != 4'd0) ? octave : 2'd0,
                                         semi_reg, idx_reg};
                        idx_reg      <= idx_p1;
                        state_reg    <= (idx_reg == 2'd3) ? ST_IDLE : ST_V_START;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `GFVS_ASSERT_IMP(a_last_is_voice3, m_tvalid, m_tlast == (m_tdata[1:0] == 2'd3), "tlast off voice 3")
    `GFVS_ASSERT_IMP(a_idle_div_free, s_tready, !dm_rsp.busy, "divider busy while idle")
    `GFVS_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready after transaction")

endmodule

FILE: tb/generative_four_voice_sequencer_checker.sv
// Checker for the four-voice sequencer: watches both streams, predicts the four voice
// results of each accepted tick and compares them. Depends on gfvs_pkg.
module generative_four_voice_sequencer_checker
    import gfvs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] voice;
        logic [3:0] semi;
        logic [1:0] oct;
        logic       trig;
        logic       muted;
        logic       mgate;
        logic [2:0] mlevel;
        logic       restart;
        logic       last;
    } voice_res_t;

    logic [5:0]  len_r;
    logic [6:0]  ax_r, ay_r;
    logic [3:0]  shift_r, space_r;
    logic [11:0] sca_r, scb_r;
    int unsigned step_c, space_c;
    logic        scale_sel;
    logic [3:0]  g_on, g_chg;
    logic [5:0]  note_r [4];
    voice_res_t  voice_q [$];

    assign pending = voice_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("%0t voice result %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic predict_tick(input logic rflag, input logic tog);
        int unsigned dv [4], ph [4], on [4], wn [4], md [4];
        int unsigned ln, rst, sh, tot, cnt, m, gate, prv, note, k, seen, semi, oct;
        logic [11:0] sm;
        voice_res_t r;
        rst = 0; tot = 0; cnt = 0;
        if (tog) scale_sel = !scale_sel;
        dv[0] = (ax_r & 3) + 1;
        ph[0] = ax_r >> 5;
        for (int i = 1; i < 4; i++) begin
            dv[i] = (ax_r & (1 << (i + 2))) ? dv[i-1] + 1 : dv[i-1] - 1;
            if (dv[i] == 0) dv[i] = i + 2;
            ph[i] = ((ax_r & (3 << i)) + i) % dv[i];
        end
        ln = len_r;
        if (ln < 1) ln = 1;
        if (ln > 32) ln = 32;
        if (rflag) begin
            step_c = 0; space_c = 0; rst = 1;
        end else begin
            space_c = (space_c + 1) & 15;
            if (step_c + 1 >= ln) begin
                step_c = 0; rst = 1;
            end else step_c++;
        end
        for (int i = 0; i < 4; i++) begin
            on[i] = ((step_c + ph[i]) / dv[i]) & 1;
            wn[i] = on[i] ? TRACK_WEIGHT[i] : 0;
            tot += wn[i];
        end
        sh = shift_r > 12 ? 12 : shift_r;
        md[0] = tot + wn[0];
        md[1] = 2 * (on[3] + on[2]) + 4 * (on[0] + on[2]);
        md[2] = (on[2] + on[1]) + 7 * (on[0] + on[3]);
        md[3] = 2 * (on[1] + on[2]) + 4 * (on[2] + on[3]) + 7 * (on[3] + on[2]);
        for (int i = 0; i < 4; i++) md[i] = (md[i] % 10) % 8;
        for (int n = 0; n < 4; n++) begin
            m = GATE_ROWS[ay_r[6:3]][n];
            gate = 0; prv = 1;
            if (m == 0) m = 5;
            for (int i = 0; i < n; i++) m = ((m & 1) << 3) | (m >> 1);
            for (int i = 0; i < 4; i++) if (on[i] && (m & (1 << i))) gate = 1;
            if (ay_r[0]) gate ^= on[n] << 1;
            if (ay_r[1]) gate ^= on[(n + 2) & 3] << 2;
            if (ay_r[2]) gate ^= on[(n + 3) & 3] << 3;
            for (int i = 0; i < 3; i++) prv &= g_chg[i] & g_on[i];
            if (n == 3 && prv) gate = 0;
            g_chg[n] = (g_on[n] != gate);
            g_on[n] = (gate != 0);
            if (g_chg[n]) begin
                note = 0;
                for (int i = 0; i < 4; i++) if (on[i] && ay_r[3 + i]) note += wn[i];
                if (ay_r[0]) note += wn[(n + 1) & 3];
                if (ay_r[1]) note += wn[(n + 2) & 3];
                if (ay_r[2]) note += wn[(n + 3) & 3];
                note += sh;
                if (sh > 6) note += n;
                note_r[n] = note[5:0];
            end
        end
        sm = scale_sel ? scb_r : sca_r;
        for (int i = 0; i < 12; i++) if (sm[i]) cnt++;
        for (int n = 0; n < 4; n++) begin
            semi = 0; oct = 0;
            r.trig = 0;
            if (cnt != 0) begin
                k = note_r[n] % cnt; seen = 0;
                for (int i = 0; i < 12; i++) begin
                    if (sm[i]) begin
                        if (seen == k && semi == 0 && seen != 99) begin
                            semi = i; seen = 99;
                        end else if (seen != 99) seen++;
                    end
                end
                oct = note_r[n] / 12;
                if (oct > 2) oct = 2;
                r.trig = g_chg[n];
            end
            r.voice = 2'(n);
            r.semi = 4'(semi);
            r.oct = 2'(oct);
            r.muted = (SPACE_ROWS[space_r | n] & space_c[3:0]) != 0;
            r.mgate = on[n][0];
            r.mlevel = 3'(md[n]);
            r.restart = rst[0];
            r.last = (n == 3);
            voice_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        voice_res_t w;
        voice_res_t g;
        if (!aresetn) begin
            len_r <= 6'd8; ax_r <= '0; ay_r <= '0; shift_r <= '0; space_r <= '0;
            sca_r <= '0; scb_r <= '0;
            step_c = 0; space_c = 0; scale_sel = 0;
            g_on = '0; g_chg = '1;
            for (int i = 0; i < 4; i++) note_r[i] = '0;
            voice_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_LENGTH:  len_r <= cfg_wdata[5:0];
                    CFG_ALGO_X:  ax_r <= cfg_wdata[6:0];
                    CFG_ALGO_Y:  ay_r <= cfg_wdata[6:0];
                    CFG_SHIFT:   shift_r <= cfg_wdata[3:0];
                    CFG_SPACE:   space_r <= cfg_wdata[3:0];
                    CFG_SCALE_A: sca_r <= cfg_wdata;
                    CFG_SCALE_B: scb_r <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_tick(s_tdata[0], s_tdata[1]);
            if (m_tvalid && m_tready) begin
                g.voice   = m_tdata[1:0];
                g.semi    = m_tdata[5:2];
                g.oct     = m_tdata[7:6];
                g.trig    = m_tdata[8];
                g.muted   = m_tdata[9];
                g.mgate   = m_tdata[10];
                g.mlevel  = m_tdata[13:11];
                g.restart = m_tdata[14];
                g.last    = m_tlast;
                if (voice_q.size() == 0) begin
                    report("with none expected", 1, 0);
                end else begin
                    w = voice_q.pop_front();
                    if (g.voice !== w.voice) report("voice_index", g.voice, w.voice);
                    if (g.semi !== w.semi) report("semitone", g.semi, w.semi);
                    if (g.oct !== w.oct) report("octave", g.oct, w.oct);
                    if (g.trig !== w.trig) report("gate_trigger", g.trig, w.trig);
                    if (g.muted !== w.muted) report("space_muted", g.muted, w.muted);
                    if (g.mgate !== w.mgate) report("mod_gate", g.mgate, w.mgate);
                    if (g.mlevel !== w.mlevel) report("mod_level", g.mlevel, w.mlevel);
                    if (g.restart !== w.restart) report("cycle_restart", g.restart, w.restart);
                    if (g.last !== w.last) report("last_voice", g.last, w.last);
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

FILE: tb/generative_four_voice_sequencer_tb.sv
// Top of the sequencer testbench: clock, reset, register phases, tick stimulus and verdict.
// Depends on gfvs_pkg, the sequencer RTL and generative_four_voice_sequencer_checker.
module generative_four_voice_sequencer_tb;
    import gfvs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0, aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = CFG_LENGTH;
    logic [11:0] cfg_wdata = 0;
    logic        s_tvalid = 0, s_tready;
    logic [7:0]  s_tdata = 0;
    logic        m_tvalid, m_tready = 0, m_tlast;
    logic [15:0] m_tdata;
    int          fail_count, pending;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    generative_four_voice_sequencer dut (.*);
    generative_four_voice_sequencer_checker u_chk (.*);

    // receiver stall pattern
    int unsigned stall_mode = 0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= 12'(val);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic send_tick(input logic rflag, input logic tog);
        s_tvalid <= 1; s_tdata <= {6'b0, tog, rflag};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic tick_group(input int count, input int rst_odds);
        int left;
        left = count;
        while (left > 0) begin
            send_tick($urandom_range(0, rst_odds) == 0, $urandom_range(0, 3) == 0);
            left--;
            if ($urandom_range(0, 2) == 0) begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 300)) @(posedge aclk);
            end
        end
        s_tvalid <= 0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: defaults with an empty scale, then full, single-note and empty scales
        send_tick(0, 0); send_tick(1, 0); send_tick(0, 1); send_tick(0, 1);
        s_tvalid <= 0;
        drain();
        write_reg(CFG_LENGTH, 0); write_reg(CFG_ALGO_X, 127); write_reg(CFG_ALGO_Y, 127);
        write_reg(CFG_SHIFT, 15); write_reg(CFG_SPACE, 15);
        write_reg(CFG_SCALE_A, 12'hfff); write_reg(CFG_SCALE_B, 12'h800);
        send_tick(0, 0); send_tick(0, 1); send_tick(1, 1); send_tick(0, 0);
        s_tvalid <= 0;
        drain();
        write_reg(CFG_LENGTH, 63); write_reg(CFG_ALGO_X, 0); write_reg(CFG_ALGO_Y, 7);
        write_reg(CFG_SHIFT, 7); write_reg(CFG_SPACE, 0);
        write_reg(CFG_SCALE_A, 12'h001); write_reg(CFG_SCALE_B, 0);
        repeat (12) send_tick(0, 0);
        send_tick(0, 1); send_tick(1, 0); send_tick(0, 1);
        s_tvalid <= 0;
        drain();
        // random phases
        for (int p = 0; p < 10; p++) begin
            write_reg(CFG_LENGTH, $urandom_range(0, 63));
            write_reg(CFG_ALGO_X, $urandom_range(0, 127));
            write_reg(CFG_ALGO_Y, $urandom_range(0, 127));
            write_reg(CFG_SHIFT, $urandom_range(0, 15));
            write_reg(CFG_SPACE, $urandom_range(0, 15));
            write_reg(CFG_SCALE_A, $urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 4095));
            write_reg(CFG_SCALE_B, $urandom_range(0, 4095));
            tick_group(22, 15);
            drain();
        end
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: generative_four_voice_sequencer.f
+incdir+design
design/gfvs_pkg.sv
design/gfvs_divmod.sv
design/generative_four_voice_sequencer.sv
tb/generative_four_voice_sequencer_checker.sv
tb/generative_four_voice_sequencer_tb.sv
